[sv/ikc_pkg.sv]
`timescale 1ns / 1ps

package ikc_pkg;

  // field widths fixed by the stream format
  localparam int OPC_W       = 2;
  localparam int COORD_W     = 8;
  localparam int PIX_W       = 32;
  localparam int COEF_W      = 16;
  localparam int FRAME_W     = 9;
  localparam int KSIZE_W     = 4;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 9;
  localparam int FRAC_SHIFT  = 15;
  localparam int PROD_W      = PIX_W + COEF_W + 1;
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 48;

  // opcodes
  localparam logic [OPC_W-1:0] OP_KERNEL  = 2'd0;
  localparam logic [OPC_W-1:0] OP_PIXEL   = 2'd1;
  localparam logic [OPC_W-1:0] OP_COMPUTE = 2'd2;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_FRAME_ROWS  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_FRAME_COLS  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_KERNEL_SIZE = 2'd2;

  // sequencer to MAC control
  typedef struct packed {
    logic clear;  // zero the accumulator
    logic tap;    // read data this cycle belongs to an in-frame tap
  } mac_ctl_t;

endpackage

[sv/ikc_ram.sv]
`timescale 1ns / 1ps

module ikc_ram #(
  parameter int DATA_W = 16,
  parameter int DEPTH  = 225
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   waddr,
  input  logic [DATA_W-1:0]          wdata,
  input  logic [$clog2(DEPTH)-1:0]   raddr,
  output logic [DATA_W-1:0]          rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[sv/ikc_mac.sv]
`timescale 1ns / 1ps

module ikc_mac #(
  parameter int ACC_W = 57
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ikc_pkg::mac_ctl_t                   ctl,
  input  logic signed [ikc_pkg::PIX_W-1:0]    pixel,
  input  logic [ikc_pkg::COEF_W-1:0]          coef,
  output logic [ikc_pkg::PIX_W-1:0]           result
);

  logic signed [ikc_pkg::PROD_W-1:0] prod_r;
  logic                              prod_vld_r;
  logic signed [ACC_W-1:0]           acc_r;
  logic signed [ACC_W-1:0]           shifted;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
    end else if (ctl.clear) begin
      prod_vld_r <= 1'b0;
    end else begin
      prod_vld_r <= ctl.tap;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= pixel * $signed({1'b0, coef});
    if (ctl.clear) begin
      acc_r <= '0;
    end else if (prod_vld_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  // floor shift, then clamp to 32 bits
  always_comb begin
    shifted = acc_r >>> ikc_pkg::FRAC_SHIFT;
    if ((&shifted[ACC_W-1:ikc_pkg::PIX_W-1]) || !(|shifted[ACC_W-1:ikc_pkg::PIX_W-1])) begin
      result = shifted[ikc_pkg::PIX_W-1:0];
    end else if (shifted[ACC_W-1]) begin
      result = 32'h8000_0000;
    end else begin
      result = 32'h7FFF_FFFF;
    end
  end

endmodule

[sv/ikc_seq.sv]
`timescale 1ns / 1ps

module ikc_seq #(
  parameter int MAX_DIM    = 256,
  parameter int MAX_KERNEL = 15
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic [ikc_pkg::OPC_W-1:0]                opcode,
  input  logic [ikc_pkg::COORD_W-1:0]              row,
  input  logic [ikc_pkg::COORD_W-1:0]              col,
  input  logic [$clog2(MAX_DIM+1)-1:0]             rows_eff,
  input  logic [$clog2(MAX_DIM+1)-1:0]             cols_eff,
  input  logic [$clog2(MAX_KERNEL+1)-1:0]          k_eff,
  output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]       img_raddr,
  output logic [$clog2(MAX_KERNEL*MAX_KERNEL)-1:0] ker_raddr,
  output ikc_pkg::mac_ctl_t                        mac_ctl,
  input  logic [ikc_pkg::PIX_W-1:0]                mac_result,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic [ikc_pkg::COORD_W-1:0]              out_row,
  output logic [ikc_pkg::COORD_W-1:0]              out_col,
  output logic [ikc_pkg::PIX_W-1:0]                out_value
);

  localparam int RW    = $clog2(MAX_DIM+1);
  localparam int KW    = $clog2(MAX_KERNEL+1);
  localparam int IA_W  = $clog2(MAX_DIM*MAX_DIM);
  localparam int KA_W  = $clog2(MAX_KERNEL*MAX_KERNEL);
  localparam int CRD_W = $clog2(256 + MAX_KERNEL) + 1;
  localparam int CMP_W = (CRD_W - 1 > RW) ? CRD_W - 1 : RW;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_DRAIN, S_DONE} state_t;

  state_t                    state_r;
  logic [KW-1:0]             m_r, n_r;
  logic signed [CRD_W-1:0]   ii_r, jj_r, jj0_r;
  logic                      drain_r;
  logic                      tap1_r;
  logic                      out_valid_r;
  logic [ikc_pkg::COORD_W-1:0] out_row_r, out_col_r, row_r, col_r;
  logic [ikc_pkg::PIX_W-1:0] out_value_r;

  logic                      in_accept, start;
  logic                      row_ok, col_ok, issue;
  logic [KW-1:0]             half, kr, kc;
  logic signed [CRD_W-1:0]   ii_start, jj_start;

  assign in_ready  = (state_r == S_IDLE);
  assign in_accept = in_valid && in_ready;
  assign start     = in_accept && (opcode == ikc_pkg::OP_COMPUTE);

  assign half     = k_eff >> 1;
  assign ii_start = $signed(CRD_W'(row)) - $signed(CRD_W'(half));
  assign jj_start = $signed(CRD_W'(col)) - $signed(CRD_W'(half));

  // tap inside the frame?
  assign row_ok = !ii_r[CRD_W-1] && (CMP_W'(ii_r[CRD_W-2:0]) < CMP_W'(rows_eff));
  assign col_ok = !jj_r[CRD_W-1] && (CMP_W'(jj_r[CRD_W-2:0]) < CMP_W'(cols_eff));
  assign issue  = (state_r == S_RUN) && row_ok && col_ok;

  // flipped kernel index
  assign kr = KW'(k_eff - KW'(1) - m_r);
  assign kc = KW'(k_eff - KW'(1) - n_r);

  assign img_raddr = IA_W'(ii_r[CRD_W-2:0]) * IA_W'(MAX_DIM) + IA_W'(jj_r[CRD_W-2:0]);
  assign ker_raddr = KA_W'(kr) * KA_W'(MAX_KERNEL) + KA_W'(kc);

  assign mac_ctl.clear = start;
  assign mac_ctl.tap   = tap1_r;

  assign out_valid = out_valid_r;
  assign out_row   = out_row_r;
  assign out_col   = out_col_r;
  assign out_value = out_value_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tap1_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      tap1_r <= issue;
      // in S_DONE the load below owns the valid flag
      if (out_valid_r && out_ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            row_r   <= row;
            col_r   <= col;
            ii_r    <= ii_start;
            jj_r    <= jj_start;
            jj0_r   <= jj_start;
            m_r     <= '0;
            n_r     <= '0;
            drain_r <= 1'b1;
            state_r <= (k_eff == '0) ? S_DRAIN : S_RUN;
          end
        end
        S_RUN: begin
          if (n_r == KW'(k_eff - KW'(1))) begin
            n_r  <= '0;
            jj_r <= jj0_r;
            if (m_r == KW'(k_eff - KW'(1))) begin
              state_r <= S_DRAIN;
            end else begin
              m_r  <= m_r + KW'(1);
              ii_r <= ii_r + CRD_W'(1);
            end
          end else begin
            n_r  <= n_r + KW'(1);
            jj_r <= jj_r + CRD_W'(1);
          end
        end
        S_DRAIN: begin
          // read and product stages empty out
          if (drain_r) begin
            drain_r <= 1'b0;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_row_r   <= row_r;
            out_col_r   <= col_r;
            out_value_r <= mac_result;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_tap_from_run: assert property (@(posedge clk) disable iff (!rst_n)
    tap1_r |-> $past(state_r == S_RUN))
    else $error("tap data without a tap issued");

  a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result loaded outside done state");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) |-> (m_r < k_eff) && (n_r < k_eff))
    else $error("tap counter out of kernel");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> (state_r == S_RUN) || (state_r == S_DRAIN))
    else $error("compute beat did not start the sequencer");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready && (state_r == S_DONE) |=> (state_r == S_DONE))
    else $error("held result overwritten");

endmodule

[sv/image_kernel_convolution.sv]
`timescale 1ns / 1ps
// One shared multiply-accumulate visits one kernel tap per cycle. No input beat is
// accepted while a compute beat is in progress, and its result waits in S_DONE while
// the previous result is still held by out_tready low.
// Reset (rst_n, synchronous, active low) sets frame 256x256 and K = 7; stores
// hold no reset value and must be written before they are read.

module image_kernel_convolution #(
  parameter int MAX_DIM    = 256,
  parameter int MAX_KERNEL = 15
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // in_tdata from bit 0: opcode[1:0], row[9:2], col[17:10],
  // pixel_value[49:18], coefficient[65:50], zero pad [71:66]
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [ikc_pkg::IN_TDATA_W-1:0]     in_tdata,
  // out_tdata from bit 0: out_row[7:0], out_col[15:8], result_value[47:16]
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [ikc_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic                               cfg_we,
  input  logic [ikc_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [ikc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int RW     = $clog2(MAX_DIM+1);
  localparam int KW     = $clog2(MAX_KERNEL+1);
  localparam int IA_W   = $clog2(MAX_DIM*MAX_DIM);
  localparam int KA_W   = $clog2(MAX_KERNEL*MAX_KERNEL);
  localparam int SAT_W  = (ikc_pkg::FRAME_W > RW) ? ikc_pkg::FRAME_W : RW;
  localparam int KSAT_W = (ikc_pkg::KSIZE_W > KW) ? ikc_pkg::KSIZE_W : KW;
  // product plus growth over the largest kernel plus a guard bit
  localparam int ACC_W  = ikc_pkg::PROD_W + $clog2(MAX_KERNEL*MAX_KERNEL) + 1;

  // input beat fields
  logic [ikc_pkg::OPC_W-1:0]   opcode;
  logic [ikc_pkg::COORD_W-1:0] row, col;
  logic [ikc_pkg::PIX_W-1:0]   pixel_value;
  logic [ikc_pkg::COEF_W-1:0]  coefficient;

  assign opcode      = in_tdata[1:0];
  assign row         = in_tdata[9:2];
  assign col         = in_tdata[17:10];
  assign pixel_value = in_tdata[49:18];
  assign coefficient = in_tdata[65:50];

  // configuration registers
  logic [ikc_pkg::FRAME_W-1:0] frame_rows_r, frame_cols_r;
  logic [ikc_pkg::KSIZE_W-1:0] kernel_size_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_rows_r  <= ikc_pkg::FRAME_W'(256);
      frame_cols_r  <= ikc_pkg::FRAME_W'(256);
      kernel_size_r <= ikc_pkg::KSIZE_W'(7);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        ikc_pkg::CFG_FRAME_ROWS:  frame_rows_r  <= cfg_wdata;
        ikc_pkg::CFG_FRAME_COLS:  frame_cols_r  <= cfg_wdata;
        ikc_pkg::CFG_KERNEL_SIZE: kernel_size_r <= cfg_wdata[ikc_pkg::KSIZE_W-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // frame and kernel size clamp to the store dimensions
  logic [RW-1:0] rows_eff, cols_eff;
  logic [KW-1:0] k_eff;

  assign rows_eff = (SAT_W'(frame_rows_r) > SAT_W'(MAX_DIM)) ? RW'(MAX_DIM) : RW'(frame_rows_r);
  assign cols_eff = (SAT_W'(frame_cols_r) > SAT_W'(MAX_DIM)) ? RW'(MAX_DIM) : RW'(frame_cols_r);
  assign k_eff    = (KSAT_W'(kernel_size_r) > KSAT_W'(MAX_KERNEL)) ?
                    KW'(MAX_KERNEL) : KW'(kernel_size_r);

  // store writes; a write outside a store is dropped
  logic            in_accept, img_we, ker_we;
  logic [IA_W-1:0] img_waddr, img_raddr;
  logic [KA_W-1:0] ker_waddr, ker_raddr;

  assign in_accept = in_tvalid && in_tready;
  assign img_we    = in_accept && (opcode == ikc_pkg::OP_PIXEL) &&
                     (int'(row) < MAX_DIM) && (int'(col) < MAX_DIM);
  assign ker_we    = in_accept && (opcode == ikc_pkg::OP_KERNEL) &&
                     (int'(row) < MAX_KERNEL) && (int'(col) < MAX_KERNEL);
  assign img_waddr = IA_W'(row) * IA_W'(MAX_DIM) + IA_W'(col);
  assign ker_waddr = KA_W'(row) * KA_W'(MAX_KERNEL) + KA_W'(col);

  logic [ikc_pkg::PIX_W-1:0]  img_rdata;
  logic [ikc_pkg::COEF_W-1:0] ker_rdata;

  ikc_ram #(
    .DATA_W (ikc_pkg::PIX_W),
    .DEPTH  (MAX_DIM*MAX_DIM)
  ) u_image (
    .clk   (clk),
    .we    (img_we),
    .waddr (img_waddr),
    .wdata (pixel_value),
    .raddr (img_raddr),
    .rdata (img_rdata)
  );

  ikc_ram #(
    .DATA_W (ikc_pkg::COEF_W),
    .DEPTH  (MAX_KERNEL*MAX_KERNEL)
  ) u_kernel (
    .clk   (clk),
    .we    (ker_we),
    .waddr (ker_waddr),
    .wdata (coefficient),
    .raddr (ker_raddr),
    .rdata (ker_rdata)
  );

  // shared multiply-accumulate: read, product and accumulate stages
  ikc_pkg::mac_ctl_t         mac_ctl;
  logic [ikc_pkg::PIX_W-1:0] mac_result;

  ikc_mac #(
    .ACC_W (ACC_W)
  ) u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (mac_ctl),
    .pixel  ($signed(img_rdata)),
    .coef   (ker_rdata),
    .result (mac_result)
  );

  // tap sequencer and result register
  logic [ikc_pkg::COORD_W-1:0] out_row, out_col;
  logic [ikc_pkg::PIX_W-1:0]   out_value;

  ikc_seq #(
    .MAX_DIM    (MAX_DIM),
    .MAX_KERNEL (MAX_KERNEL)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .opcode     (opcode),
    .row        (row),
    .col        (col),
    .rows_eff   (rows_eff),
    .cols_eff   (cols_eff),
    .k_eff      (k_eff),
    .img_raddr  (img_raddr),
    .ker_raddr  (ker_raddr),
    .mac_ctl    (mac_ctl),
    .mac_result (mac_result),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_row    (out_row),
    .out_col    (out_col),
    .out_value  (out_value)
  );

  assign out_tdata = {out_value, out_col, out_row};

endmodule

[test/tb.sv]
`timescale 1ns / 1ps

// one input beat, fields unpacked
typedef struct {
  logic [ikc_pkg::OPC_W-1:0]   op;
  logic [ikc_pkg::COORD_W-1:0] row;
  logic [ikc_pkg::COORD_W-1:0] col;
  logic [ikc_pkg::PIX_W-1:0]   pix;
  logic [ikc_pkg::COEF_W-1:0]  coef;
} conv_cmd_t;

// one result beat
typedef struct {
  logic [ikc_pkg::COORD_W-1:0]      row;
  logic [ikc_pkg::COORD_W-1:0]      col;
  logic signed [ikc_pkg::PIX_W-1:0] value;
} conv_pixel_t;

class pixel_scoreboard;
  localparam int DIM = 256;
  localparam int KMAX = 15;
  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;

  int unsigned rows_cfg;
  int unsigned cols_cfg;
  int unsigned ksize_cfg;
  int          pix_mem  [DIM][DIM];
  bit          pix_set  [DIM][DIM];
  bit [15:0]   coef_mem [KMAX][KMAX];
  bit          coef_set [KMAX][KMAX];
  conv_pixel_t awaited_pixels [$];
  int          errors;

  function new();
    rows_cfg  = 256;
    cols_cfg  = 256;
    ksize_cfg = 7;
    errors    = 0;
  endfunction

  function void set_reg(logic [ikc_pkg::CFG_ADDR_W-1:0] idx, int unsigned value);
    case (idx)
      ikc_pkg::CFG_FRAME_ROWS:  rows_cfg  = value & 'h1FF;
      ikc_pkg::CFG_FRAME_COLS:  cols_cfg  = value & 'h1FF;
      ikc_pkg::CFG_KERNEL_SIZE: ksize_cfg = value & 'hF;
      default: ;
    endcase
  endfunction

  // bounds actually in force once the registers saturate
  function int rows_in_use();
    return (rows_cfg > DIM) ? DIM : rows_cfg;
  endfunction

  function int cols_in_use();
    return (cols_cfg > DIM) ? DIM : cols_cfg;
  endfunction

  function int taps();
    return (ksize_cfg > KMAX) ? KMAX : ksize_cfg;
  endfunction

  // zero-padded window sum with flipped kernel, floor shift, saturate
  function logic signed [31:0] window_sum(int r, int c);
    int     nr, nc, k, half, ii, jj, m, n;
    longint acc;
    nr   = rows_in_use();
    nc   = cols_in_use();
    k    = taps();
    half = k / 2;
    acc  = 0;
    for (m = 0; m < k; m++) begin
      for (n = 0; n < k; n++) begin
        ii = r + m - half;
        jj = c + n - half;
        if (ii >= 0 && ii < nr && jj >= 0 && jj < nc)
          acc += longint'(pix_mem[ii][jj]) * longint'(coef_mem[k-1-m][k-1-n]);
      end
    end
    acc = acc >>> ikc_pkg::FRAC_SHIFT;
    if (acc > SAT_HI) acc = SAT_HI;
    if (acc < SAT_LO) acc = SAT_LO;
    return acc[31:0];
  endfunction

  function void note_beat(conv_cmd_t cmd);
    conv_pixel_t exp_px;
    case (cmd.op)
      ikc_pkg::OP_KERNEL: begin
        if (cmd.row < KMAX && cmd.col < KMAX) begin
          coef_mem[cmd.row][cmd.col] = cmd.coef;
          coef_set[cmd.row][cmd.col] = 1'b1;
        end
      end
      ikc_pkg::OP_PIXEL: begin
        pix_mem[cmd.row][cmd.col] = cmd.pix;
        pix_set[cmd.row][cmd.col] = 1'b1;
      end
      ikc_pkg::OP_COMPUTE: begin
        exp_px.row   = cmd.row;
        exp_px.col   = cmd.col;
        exp_px.value = window_sum(int'(cmd.row), int'(cmd.col));
        awaited_pixels.push_back(exp_px);
      end
      default: ;
    endcase
  endfunction

  function void check_beat(conv_pixel_t got);
    conv_pixel_t exp_px;
    if (awaited_pixels.size() == 0) begin
      $error("unexpected result beat: row %0d col %0d value %0d",
             got.row, got.col, got.value);
      errors++;
      return;
    end
    exp_px = awaited_pixels.pop_front();
    if (got.row !== exp_px.row) begin
      $error("out_row: expected %0d, got %0d", exp_px.row, got.row);
      errors++;
    end
    if (got.col !== exp_px.col) begin
      $error("out_col: expected %0d, got %0d", exp_px.col, got.col);
      errors++;
    end
    if (got.value !== exp_px.value) begin
      $error("result_value: expected %0d, got %0d", exp_px.value, got.value);
      errors++;
    end
  endfunction
endclass

module tb;

  // opcode the block must ignore
  localparam logic [ikc_pkg::OPC_W-1:0] OP_UNUSED = 2'd3;

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [ikc_pkg::IN_TDATA_W-1:0]  in_tdata;
  logic                            out_tvalid;
  logic                            out_tready;
  logic [ikc_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                            cfg_we;
  logic [ikc_pkg::CFG_ADDR_W-1:0]  cfg_addr;
  logic [ikc_pkg::CFG_DATA_W-1:0]  cfg_wdata;

  // idle odds in percent, per side
  int unsigned send_idle = 11;
  int unsigned recv_idle = 64;

  pixel_scoreboard pix_sb = new();

  image_kernel_convolution DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

  // receiver: back-pressure redrawn every falling edge
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      out_tready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  // monitor: both channels sampled on the rising edge
  always @(posedge clk) begin
    conv_cmd_t   cmd;
    conv_pixel_t px;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        cmd.op   = in_tdata[1:0];
        cmd.row  = in_tdata[9:2];
        cmd.col  = in_tdata[17:10];
        cmd.pix  = in_tdata[49:18];
        cmd.coef = in_tdata[65:50];
        pix_sb.note_beat(cmd);
      end
      if (out_tvalid && out_tready) begin
        px.row   = out_tdata[7:0];
        px.col   = out_tdata[15:8];
        px.value = out_tdata[47:16];
        pix_sb.check_beat(px);
      end
    end
  end

  // mostly modest magnitudes so sums do not always clip; the extremes now and then
  function automatic logic [ikc_pkg::PIX_W-1:0] rand_pixel();
    int sel;
    int v;
    sel = $urandom_range(0, 31);
    if (sel == 0) return 32'h7FFF_FFFF;
    if (sel == 1) return 32'h8000_0000;
    if (sel < 4) return $urandom;
    v = $urandom_range(0, 2097152);
    return v - 1048576;
  endfunction

  function automatic logic [ikc_pkg::COEF_W-1:0] rand_coef();
    int sel;
    sel = $urandom_range(0, 15);
    if (sel == 0) return 16'hFFFF;
    if (sel == 1) return 16'h0000;
    return ikc_pkg::COEF_W'($urandom_range(0, 65535));
  endfunction

  // coordinate biased to a small corner box and the far frame edge
  function automatic logic [ikc_pkg::COORD_W-1:0] pick_coord(input int limit);
    int sel;
    sel = $urandom_range(0, 99);
    if (limit == 0 || sel >= 85) return ikc_pkg::COORD_W'($urandom_range(0, 255));
    if (sel >= 65)
      return ikc_pkg::COORD_W'(limit - 1 -
                               int'($urandom_range(0, (limit > 3) ? 2 : limit - 1)));
    return ikc_pkg::COORD_W'($urandom_range(0, ((limit > 24) ? 24 : limit) - 1));
  endfunction

  // one beat on the input channel; entered and left at a falling edge
  task automatic send_cmd(input conv_cmd_t cmd);
    while ($urandom_range(0, 99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'd0, cmd.coef, cmd.pix, cmd.col, cmd.row, cmd.op};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // unused fields carry random bits throughout
  task automatic send_op(input logic [ikc_pkg::OPC_W-1:0] op, input int r, input int c,
                         input logic [ikc_pkg::PIX_W-1:0] pix,
                         input logic [ikc_pkg::COEF_W-1:0] coef);
    conv_cmd_t cmd;
    cmd.op   = op;
    cmd.row  = ikc_pkg::COORD_W'(r);
    cmd.col  = ikc_pkg::COORD_W'(c);
    cmd.pix  = pix;
    cmd.coef = coef;
    send_cmd(cmd);
  endtask

  task automatic write_coef(input int r, input int c, input logic [ikc_pkg::COEF_W-1:0] v);
    send_op(ikc_pkg::OP_KERNEL, r, c, $urandom, v);
  endtask

  task automatic write_pixel(input int r, input int c, input logic [ikc_pkg::PIX_W-1:0] v);
    send_op(ikc_pkg::OP_PIXEL, r, c, v, ikc_pkg::COEF_W'($urandom));
  endtask

  // stores are undefined until written: fill every tap the window will read first
  task automatic compute_at(input int r, input int c);
    int nr, nc, k, half, ii, jj, m, n;
    nr   = pix_sb.rows_in_use();
    nc   = pix_sb.cols_in_use();
    k    = pix_sb.taps();
    half = k / 2;
    for (m = 0; m < k; m++)
      for (n = 0; n < k; n++)
        if (!pix_sb.coef_set[m][n]) write_coef(m, n, rand_coef());
    for (m = 0; m < k; m++) begin
      for (n = 0; n < k; n++) begin
        ii = r + m - half;
        jj = c + n - half;
        if (ii >= 0 && ii < nr && jj >= 0 && jj < nc && !pix_sb.pix_set[ii][jj])
          write_pixel(ii, jj, rand_pixel());
      end
    end
    send_op(ikc_pkg::OP_COMPUTE, r, c, $urandom, ikc_pkg::COEF_W'($urandom));
  endtask

  // wait for every result, then let any write still in flight finish
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pix_sb.awaited_pixels.size() != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  task automatic write_reg(input logic [ikc_pkg::CFG_ADDR_W-1:0] idx,
                           input int unsigned value);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= ikc_pkg::CFG_DATA_W'(value);
    @(negedge clk);
    cfg_we <= 1'b0;
    pix_sb.set_reg(idx, value);
    @(negedge clk);
  endtask

  task automatic set_frame(input int unsigned rows, input int unsigned cols,
                           input int unsigned k);
    settle();
    write_reg(ikc_pkg::CFG_FRAME_ROWS, rows);
    write_reg(ikc_pkg::CFG_FRAME_COLS, cols);
    write_reg(ikc_pkg::CFG_KERNEL_SIZE, k);
  endtask

  // random mix; ignored beats (unused opcode, kernel writes off the store) not counted
  task automatic random_items(input int count);
    int done, sel, r, c;
    done = 0;
    while (done < count) begin
      sel = $urandom_range(0, 99);
      if (sel < 5) begin
        send_op(OP_UNUSED, $urandom_range(0, 255), $urandom_range(0, 255),
                $urandom, ikc_pkg::COEF_W'($urandom));
      end else if (sel < 20) begin
        if ($urandom_range(0, 4) == 0) begin
          r = $urandom_range(0, 255);
          c = $urandom_range(0, 255);
        end else begin
          r = $urandom_range(0, 14);
          c = $urandom_range(0, 14);
        end
        write_coef(r, c, rand_coef());
        if (r < 15 && c < 15) done++;
      end else if (sel < 45) begin
        write_pixel(pick_coord(pix_sb.rows_in_use()), pick_coord(pix_sb.cols_in_use()),
                    rand_pixel());
        done++;
      end else begin
        compute_at(pick_coord(pix_sb.rows_in_use()), pick_coord(pix_sb.cols_in_use()));
        done++;
      end
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset frame 256x256, 7x7 kernel: corners, edges, store limits
    write_coef(0, 0, 16'hFFFF);
    write_coef(14, 14, 16'h0000);
    write_coef(15, 3, 16'hFFFF);         // row off the kernel store, dropped
    write_coef(255, 255, 16'h1234);      // dropped as well
    write_pixel(0, 0, 32'h7FFF_FFFF);
    write_pixel(255, 255, 32'h8000_0000);
    write_pixel(3, 3, 32'h0000_0000);
    send_op(OP_UNUSED, 255, 255, 32'hFFFF_FFFF, 16'hFFFF);
    compute_at(0, 0);
    compute_at(255, 255);
    compute_at(128, 3);
    compute_at(3, 255);
    random_items(40);

    set_frame(8, 8, 3);
    random_items(55);

    // single pixel, single tap: clipping both ways and the floor shift
    set_frame(1, 1, 1);
    write_pixel(0, 0, 32'h7FFF_FFFF);
    write_coef(0, 0, 16'hFFFF);
    compute_at(0, 0);
    write_pixel(0, 0, 32'h8000_0000);
    compute_at(0, 0);
    write_coef(0, 0, 16'h0000);
    compute_at(0, 0);
    write_pixel(0, 0, 32'hFFFF_FFFF);
    write_coef(0, 0, 16'h0001);
    compute_at(0, 0);
    compute_at(5, 5);                    // outside the frame, all padding
    random_items(40);

    // second regime: sender slow, receiver eager
    send_idle = 64;
    recv_idle = 11;
    set_frame(0, 5, 4);                  // empty frame, even kernel
    random_items(40);
    set_frame(511, 300, 15);             // frame registers clip to 256
    random_items(55);
    set_frame(12, 20, 0);                // no taps at all
    random_items(40);

    // last regime: no idling either side
    send_idle = 0;
    recv_idle = 0;
    set_frame(16, 10, 5);
    random_items(55);
    set_frame(256, 256, 15);
    random_items(55);
    set_frame(256, 1, 2);
    random_items(40);

    settle();
    if (pix_sb.errors == 0 && pix_sb.awaited_pixels.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
